@@ hw/rtl/fbso_pkg.sv @@
// Shared constants, codes and the command type for the framed byte stream bit override unit.
// No dependencies; used by every module of the block.
package fbso_pkg;

	localparam int STREAM_LENGTH = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] OP_STREAM = 3'd0;
	localparam logic [2:0] OP_FORCE = 3'd1;
	localparam logic [2:0] OP_RELEASE = 3'd2;
	localparam logic [2:0] OP_WMASK = 3'd3;
	localparam logic [2:0] OP_WDATA = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TOO_LONG = 2'd1;
	localparam logic [1:0] ST_POS_RANGE = 2'd2;
	localparam logic [1:0] ST_BIT_RANGE = 2'd3;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_STREAM = 3'd1;
	localparam logic [2:0] KIND_FORCE = 3'd2;
	localparam logic [2:0] KIND_RELEASE = 3'd3;
	localparam logic [2:0] KIND_WMASK = 3'd4;
	localparam logic [2:0] KIND_WDATA = 3'd5;

	localparam logic [7:0] FRAME_START = 8'h80;
	localparam logic [6:0] MASK_BITS = 7'h7f;
	localparam logic [2:0] BIT_LIMIT = 3'd7;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] addr;
		logic [7:0] value;
		logic [2:0] bitsel;
		logic [1:0] status;
	} cmd_t;

endpackage

@@ hw/rtl/fbso_front.sv @@
// Front part: accepts items, tracks the frame position and classifies each item into a command.
// Depends on fbso_pkg.
module fbso_front #(
	parameter int STREAM_LENGTH = fbso_pkg::STREAM_LENGTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [2:0]          operation,
	input  logic [7:0]          byte_value,
	input  logic [7:0]          position,
	input  logic [2:0]          bit_index,
	output fbso_pkg::cmd_t      cmd
);

	localparam int PW = $clog2(STREAM_LENGTH + 1);

	logic [PW-1:0] pos_q;
	logic [PW-1:0] cur;
	logic [PW-1:0] pos_next;
	logic          pos_bad;
	logic          bit_bad;

	assign cur = ((byte_value & fbso_pkg::FRAME_START) != 8'd0) ? '0 : pos_q;
	assign pos_bad = position >= 8'(STREAM_LENGTH);
	assign bit_bad = bit_index >= fbso_pkg::BIT_LIMIT;

	always_comb begin
		cmd.kind = fbso_pkg::KIND_NONE;
		cmd.addr = 8'd0;
		cmd.value = byte_value;
		cmd.bitsel = bit_index;
		cmd.status = fbso_pkg::ST_OK;
		pos_next = pos_q;
		case (operation)
			fbso_pkg::OP_STREAM: begin
				pos_next = cur;
				if (cur >= PW'(STREAM_LENGTH)) begin
					cmd.status = fbso_pkg::ST_TOO_LONG;
				end else begin
					cmd.kind = fbso_pkg::KIND_STREAM;
					cmd.addr = 8'(cur);
					pos_next = PW'(cur + 1'b1);
				end
			end
			fbso_pkg::OP_FORCE, fbso_pkg::OP_RELEASE: begin
				if (pos_bad) begin
					cmd.status = fbso_pkg::ST_POS_RANGE;
				end else if (bit_bad) begin
					cmd.status = fbso_pkg::ST_BIT_RANGE;
				end else begin
					cmd.kind = (operation == fbso_pkg::OP_FORCE) ?
						fbso_pkg::KIND_FORCE : fbso_pkg::KIND_RELEASE;
					cmd.addr = position;
				end
			end
			fbso_pkg::OP_WMASK, fbso_pkg::OP_WDATA: begin
				if (pos_bad) begin
					cmd.status = fbso_pkg::ST_POS_RANGE;
				end else begin
					cmd.kind = (operation == fbso_pkg::OP_WMASK) ?
						fbso_pkg::KIND_WMASK : fbso_pkg::KIND_WDATA;
					cmd.addr = position;
				end
			end
			default: begin
				cmd.kind = fbso_pkg::KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= pos_next;
		end
	end

endmodule

@@ hw/rtl/fbso_queue.sv @@
// Short command queue between the front and back parts.
// Depends on fbso_pkg for the command type and depth.
module fbso_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fbso_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output fbso_pkg::cmd_t head_cmd
);

	localparam int DEPTH = fbso_pkg::QUEUE_DEPTH;
	localparam int QW = $clog2(DEPTH);

	fbso_pkg::cmd_t  slot_q [DEPTH];
	logic [QW-1:0]   wr_ptr_q;
	logic [QW-1:0]   rd_ptr_q;
	logic [QW:0]     count_q;

	assign full = count_q == (QW + 1)'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= (QW + 1)'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= (QW + 1)'(count_q - 1'b1);
			end
		end
	end

endmodule

@@ hw/rtl/fbso_back.sv @@
// Back part: reads the override table, merges stream bytes, applies updates, holds the result.
// Depends on fbso_pkg; holds the override memory and the output register.
module fbso_back #(
	parameter int STREAM_LENGTH = fbso_pkg::STREAM_LENGTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  fbso_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic [1:0]     status,
	output logic           byte_forwarded
);

	localparam int AW = (STREAM_LENGTH > 1) ? $clog2(STREAM_LENGTH) : 1;

	// mask in [14:8], data in [7:0]
	logic [14:0]              mem [STREAM_LENGTH];
	logic [STREAM_LENGTH-1:0] valid_q;

	logic           s1_valid_q;
	fbso_pkg::cmd_t cmd_s1;
	logic [14:0]    rd_word_s1;
	logic           rd_vld_s1;
	logic           byp_s1;
	logic [14:0]    byp_word_s1;

	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic [1:0]     status_q;
	logic           fwd_q;

	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;
	logic           s1_adv;
	logic           wr_en;
	logic [14:0]    word;
	logic [6:0]     m;
	logic [7:0]     d;
	logic [6:0]     b;
	logic [6:0]     m_new;
	logic [7:0]     d_new;
	logic [7:0]     merged;

	assign s1_adv = s1_valid_q && (!out_valid_q || !out_stall);
	assign q_pop = q_valid && (!s1_valid_q || s1_adv);
	assign rd_addr = q_cmd.addr[AW-1:0];
	assign wr_addr = cmd_s1.addr[AW-1:0];

	assign word = byp_s1 ? byp_word_s1 : (rd_vld_s1 ? rd_word_s1 : 15'd0);
	assign m = word[14:8];
	assign d = word[7:0];
	assign b = 7'(7'd1 << cmd_s1.bitsel);
	assign merged = (cmd_s1.value & ~{1'b0, m}) | ({1'b0, m} & d);

	always_comb begin
		m_new = m;
		d_new = d;
		wr_en = 1'b0;
		case (cmd_s1.kind)
			fbso_pkg::KIND_FORCE: begin
				m_new = m | b;
				d_new = (d & ~{1'b0, b}) | (8'(cmd_s1.value[0]) << cmd_s1.bitsel);
				wr_en = 1'b1;
			end
			fbso_pkg::KIND_RELEASE: begin
				m_new = m & ~b;
				wr_en = 1'b1;
			end
			fbso_pkg::KIND_WMASK: begin
				m_new = cmd_s1.value[6:0] & fbso_pkg::MASK_BITS;
				wr_en = 1'b1;
			end
			fbso_pkg::KIND_WDATA: begin
				d_new = cmd_s1.value;
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		wr_en = wr_en && s1_adv;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {m_new, d_new};
		end
		if (q_pop) begin
			rd_word_s1 <= mem[rd_addr];
			cmd_s1 <= q_cmd;
			byp_word_s1 <= {m_new, d_new};
		end
		if (s1_adv) begin
			out_byte_q <= (cmd_s1.kind == fbso_pkg::KIND_STREAM) ? merged : 8'd0;
			status_q <= cmd_s1.status;
			fwd_q <= cmd_s1.kind == fbso_pkg::KIND_STREAM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			s1_valid_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			byp_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (q_pop) begin
				s1_valid_q <= 1'b1;
				rd_vld_s1 <= valid_q[rd_addr];
				byp_s1 <= wr_en && (wr_addr == rd_addr);
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign status = status_q;
	assign byte_forwarded = fwd_q;

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (32'(wr_addr) < STREAM_LENGTH))
		else $error("table write beyond frame length");

	a_fwd_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fwd_q) |-> (status_q == fbso_pkg::ST_OK))
		else $error("forwarded beat with error status");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !fwd_q) |-> (out_byte_q == 8'd0))
		else $error("non-forwarded beat carries a byte");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && out_stall) |=> s1_valid_q)
		else $error("back stage lost a command under stall");

endmodule

@@ hw/rtl/framed_byte_stream_bit_override_unit.sv @@
// Top level of the framed byte stream bit override unit.
// Depends on fbso_pkg, fbso_front, fbso_queue and fbso_back.
//
// Input channel (in_valid / in_stall): one beat per item carrying operation, byte_value,
// position and bit_index. Operation 0 is a stream byte; a byte with bit 7 set starts a frame.
// Operations 1..4 force a bit, release a bit, write a mask byte or write a data byte of the
// override table at the given frame position.
// Output channel (out_valid / out_stall): exactly one beat per accepted item, in order,
// carrying out_byte, status and byte_forwarded.
// Each item passes through the command queue, the table read stage and the output register.
// Throughput: one item per cycle while out_stall is low; the override table has one read
// and one write port; a write to the entry being read in the same cycle goes to the reader.
// A four-entry command queue sits between the front and back parts; in_stall rises only
// when that queue is full, so items keep being taken while a result waits at the output.
// A stalled output beat holds its value until taken.
// Reset: frame position returns to 0 and every table entry reads as zero (no overrides)
// until written; the block takes items in the first cycle after reset.
module framed_byte_stream_bit_override_unit #(
	parameter int STREAM_LENGTH = fbso_pkg::STREAM_LENGTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [7:0] byte_value,
	input  logic [7:0] position,
	input  logic [2:0] bit_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic       byte_forwarded
);

	fbso_pkg::cmd_t front_cmd;
	fbso_pkg::cmd_t head_cmd;
	logic           accept;
	logic           full;
	logic           head_valid;
	logic           pop;

	assign in_stall = full;
	assign accept = in_valid && !full;

	fbso_front #(
		.STREAM_LENGTH(STREAM_LENGTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.byte_value(byte_value),
		.position  (position),
		.bit_index (bit_index),
		.cmd       (front_cmd)
	);

	fbso_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_cmd  (front_cmd),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	fbso_back #(
		.STREAM_LENGTH(STREAM_LENGTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (head_valid),
		.q_cmd         (head_cmd),
		.q_pop         (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.status        (status),
		.byte_forwarded(byte_forwarded)
	);

endmodule
